// File: rtl/csds_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and saturating helpers for the coupled spring-damper step.
// No dependencies.
package csds_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_W             = 31;
    localparam int CFG_IDX_W         = 3;
    localparam int SQRT_ITERS        = 32;
    localparam int CNT_W             = $clog2(SQRT_ITERS);

    typedef logic signed [31:0] t_word;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_PRESS   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INVERSE_MASS  = 3'd0,
        CFG_BODY_DAMPING  = 3'd1,
        CFG_BODY_SPRING   = 3'd2,
        CFG_LINK_SPRING   = 3'd3,
        CFG_LINK_DAMPING  = 3'd4,
        CFG_FOLLOWER_GAIN = 3'd5,
        CFG_REST_LENGTH   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0] op;
        t_word      accel_x;
        t_word      accel_y;
        t_word      pointer_x;
        t_word      pointer_y;
    } t_in;

    typedef struct packed {
        t_word leader_x;
        t_word leader_y;
        t_word follower_x;
        t_word follower_y;
        t_word link_force_x;
        t_word link_force_y;
    } t_out;

    typedef enum logic [3:0] {
        STEP_RP, STEP_RV, STEP_LP, STEP_LV, STEP_DAMP, STEP_SPR, STEP_IMASS,
        STEP_SQ, STEP_UR, STEP_LS, STEP_LD, STEP_FG, STEP_FV, STEP_FP
    } t_step;

    typedef struct packed {
        logic  load;
        logic  mul;
        logic  wb;
        t_step step;
        logic  axis;
        logic  sqrt_run;
        logic  div_init;
        logic  div_run;
        logic  div_end;
        logic  out_load;
    } t_cmd;

    function automatic t_word f_sat33(input logic signed [32:0] v);
        if (v > 33'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (v < -33'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic t_word f_add(input t_word a, input t_word b);
        return f_sat33({a[31], a} + {b[31], b});
    endfunction

    function automatic t_word f_sub(input t_word a, input t_word b);
        return f_sat33({a[31], a} - {b[31], b});
    endfunction

endpackage

// File: rtl/csds_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the step: handshakes, multiply steps, root and divide iterations.
// Depends on csds_pkg.
module csds_ctrl #(
    parameter int FRACTION_BITS = csds_pkg::FRACTION_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_op,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output csds_pkg::t_cmd  o_cmd
);
    import csds_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_MUL   = 8'b0000_0010,
        ST_WB    = 8'b0000_0100,
        ST_SQRT  = 8'b0000_1000,
        ST_DINIT = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_DEND  = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } t_state;

    t_state           r_state, n_state;
    t_step            r_step, n_step;
    logic             r_axis, n_axis;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovalid, n_ovalid;
    logic             in_fire;
    logic             out_free;

    function automatic t_step f_next(input t_step s);
        case (s)
            STEP_RP:   return STEP_RV;
            STEP_RV:   return STEP_LP;
            STEP_LP:   return STEP_LV;
            STEP_LV:   return STEP_DAMP;
            STEP_DAMP: return STEP_SPR;
            STEP_SPR:  return STEP_IMASS;
            STEP_UR:   return STEP_LS;
            STEP_LS:   return STEP_LD;
            STEP_LD:   return STEP_FG;
            STEP_FG:   return STEP_FV;
            STEP_FV:   return STEP_FP;
            default:   return s;
        endcase
    endfunction

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_ovalid || i_out_ready;
    assign o_out_valid = r_ovalid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = in_fire;
        o_cmd.mul      = (r_state == ST_MUL);
        o_cmd.wb       = (r_state == ST_WB);
        o_cmd.step     = r_step;
        o_cmd.axis     = r_axis;
        o_cmd.sqrt_run = (r_state == ST_SQRT);
        o_cmd.div_init = (r_state == ST_DINIT);
        o_cmd.div_run  = (r_state == ST_DIV);
        o_cmd.div_end  = (r_state == ST_DEND);
        o_cmd.out_load = (r_state == ST_OUT) && out_free;
    end

    always_comb begin
        n_state  = r_state;
        n_step   = r_step;
        n_axis   = r_axis;
        n_cnt    = r_cnt;
        n_ovalid = o_cmd.out_load ? 1'b1 : (i_out_ready ? 1'b0 : r_ovalid);
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_step  = STEP_RP;
                    n_axis  = 1'b0;
                    n_state = (i_op == OP_TICK) ? ST_MUL : ST_OUT;
                end
            end
            ST_MUL: begin
                n_state = ST_WB;
            end
            ST_WB: begin
                n_state = ST_MUL;
                if (r_step == STEP_IMASS) begin
                    n_step = r_axis ? STEP_SQ : STEP_RP;
                    n_axis = !r_axis;
                end else if (r_step == STEP_SQ) begin
                    n_axis = !r_axis;
                    if (r_axis) begin
                        n_state = ST_SQRT;
                        n_cnt   = '0;
                    end
                end else if (r_step == STEP_FP) begin
                    n_step = STEP_UR;
                    n_axis = !r_axis;
                    if (r_axis) begin
                        n_state = ST_OUT;
                    end
                end else begin
                    n_step = f_next(r_step);
                end
            end
            ST_SQRT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SQRT_ITERS - 1)) begin
                    n_state = ST_DINIT;
                    n_axis  = 1'b0;
                end
            end
            ST_DINIT: begin
                n_state = ST_DIV;
                n_cnt   = '0;
            end
            ST_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRACTION_BITS)) begin
                    n_state = ST_DEND;
                end
            end
            ST_DEND: begin
                n_axis = !r_axis;
                if (r_axis) begin
                    n_state = ST_MUL;
                    n_step  = STEP_UR;
                end else begin
                    n_state = ST_DINIT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= STEP_RP;
            r_axis   <= 1'b0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_step   <= n_step;
            r_axis   <= n_axis;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
    end

    a_no_tick_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_op != OP_TICK) |=> r_state == ST_OUT)
        else $error("press or release did not go straight to result");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_cnt <= CNT_W'(FRACTION_BITS))
        else $error("divide iteration count overrun");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && r_ovalid && !i_out_ready |=> r_state == ST_OUT)
        else $error("result dropped while output register busy");

endmodule

// File: rtl/csds_datapath.sv
`timescale 1ns / 1ps
// Body state, configuration registers, shared multiplier, root and divide units.
// Depends on csds_pkg; driven by commands from csds_ctrl.
module csds_datapath #(
    parameter int FRACTION_BITS = csds_pkg::FRACTION_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  csds_pkg::t_cmd                     i_cmd,
    input  csds_pkg::t_in                      i_in_data,
    input  logic                               i_cfg_valid,
    input  logic [csds_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [csds_pkg::CFG_W-1:0]         i_cfg_data,
    output csds_pkg::t_out                     o_out_data
);
    import csds_pkg::*;

    localparam t_word ONE  = 32'(64'd1 << FRACTION_BITS);
    localparam t_word TWO  = 32'(64'd2 << FRACTION_BITS);
    localparam t_word DT   = 32'((2 * (64'd1 << FRACTION_BITS) + 50) / 100);
    localparam logic [CFG_W-1:0] SEVEN_RST = CFG_W'(7 * (64'd1 << FRACTION_BITS));
    localparam logic [CFG_W-1:0] REST_RST  = CFG_W'((9 * (64'd1 << FRACTION_BITS) + 5) / 10);
    localparam logic [CFG_W-1:0] ONE_RST   = CFG_W'(64'd1 << FRACTION_BITS);
    localparam logic signed [63:0] HALF    = 64'sd1 <<< (FRACTION_BITS - 1);

    logic [CFG_W-1:0] r_inv_mass, r_body_damp, r_body_spring, r_link_spring;
    logic [CFG_W-1:0] r_link_damp, r_fol_gain, r_rest_len;

    t_word r_rp[2], r_rv[2], r_ra[2], r_lp[2], r_lv[2], r_la[2];
    t_word r_fp[2], r_fv[2], r_ef[2], r_lf[2];
    t_word r_acc[2], r_d[2], r_u[2];
    t_word r_t;

    logic signed [63:0]     r_prod;
    logic [63:0]            r_sq0;
    logic [63:0]            r_sqv, r_root, r_bit;
    logic [33:0]            r_rem;
    logic [FRACTION_BITS:0] r_quo;
    t_out                   r_out;

    logic  ax;
    t_word op_a, op_b, q, d_now, rel;
    logic [63:0] sq_try;
    logic [31:0] len, dabs;
    logic        div_ge;
    logic [33:0] div_diff;
    t_word       quo_ext;

    function automatic t_word f_cfg(input logic [CFG_W-1:0] c);
        return t_word'({1'b0, c});
    endfunction

    function automatic t_word f_qround(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = (p + HALF) >>> FRACTION_BITS;
        if (s > 64'sd2147483647) begin
            return 32'sh7fff_ffff;
        end else if (s < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    assign ax       = i_cmd.axis;
    assign q        = f_qround(r_prod);
    assign d_now    = f_sub(r_lp[ax], r_fp[ax]);
    assign rel      = f_sub(r_fv[ax], r_lv[ax]);
    assign sq_try   = r_root + r_bit;
    assign len      = r_root[31:0];
    assign dabs     = r_d[ax][31] ? (~r_d[ax] + 32'd1) : r_d[ax];
    assign div_ge   = r_rem >= {2'b00, len};
    assign div_diff = div_ge ? (r_rem - {2'b00, len}) : r_rem;
    assign quo_ext  = t_word'({{(31 - FRACTION_BITS){1'b0}}, r_quo});
    assign o_out_data = r_out;

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (i_cmd.step)
            STEP_RP:    begin op_a = r_rv[ax];              op_b = DT; end
            STEP_RV:    begin op_a = r_ra[ax];              op_b = DT; end
            STEP_LP:    begin op_a = r_lv[ax];              op_b = DT; end
            STEP_LV:    begin op_a = r_la[ax];              op_b = DT; end
            STEP_DAMP:  begin
                op_a = f_cfg(r_body_damp);
                op_b = f_sub(r_rv[ax], r_lv[ax]);
            end
            STEP_SPR:   begin
                op_a = f_cfg(r_body_spring);
                op_b = f_sub(r_rp[ax], r_lp[ax]);
            end
            STEP_IMASS: begin op_a = f_cfg(r_inv_mass);     op_b = r_t; end
            STEP_SQ:    begin op_a = d_now;                 op_b = d_now; end
            STEP_UR:    begin op_a = r_u[ax];               op_b = f_cfg(r_rest_len); end
            STEP_LS:    begin op_a = f_cfg(r_link_spring);  op_b = r_t; end
            STEP_LD:    begin
                op_a = f_cfg(r_link_damp);
                op_b = f_sub(r_lv[ax], r_fv[ax]);
            end
            STEP_FG:    begin op_a = f_cfg(r_fol_gain);     op_b = r_t; end
            STEP_FV:    begin op_a = r_t;                   op_b = DT; end
            STEP_FP:    begin op_a = r_fv[ax];              op_b = DT; end
            default:    begin op_a = '0;                    op_b = '0; end
        endcase
    end

    // multiplier, sqrt, divide, accel capture and output datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_prod <= op_a * op_b;
        end
        if (i_cmd.load) begin
            r_acc[0] <= i_in_data.accel_x;
            r_acc[1] <= i_in_data.accel_y;
        end
        if (i_cmd.wb) begin
            case (i_cmd.step)
                STEP_DAMP:  r_t <= q;
                STEP_SPR:   r_t <= f_add(f_add(r_t, q), r_ef[ax]);
                STEP_UR:    r_t <= f_sub(r_d[ax], q);
                STEP_LS:    r_t <= q;
                STEP_LD:    r_t <= f_add(r_t, q);
                STEP_FG:    r_t <= f_sub(q, f_add(rel, rel));
                STEP_SQ: begin
                    r_d[ax] <= d_now;
                    if (!ax) begin
                        r_sq0 <= r_prod;
                    end else begin
                        r_sqv  <= r_sq0 + r_prod;
                        r_root <= '0;
                        r_bit  <= 64'h4000_0000_0000_0000;
                    end
                end
                default: ;
            endcase
        end
        if (i_cmd.sqrt_run) begin
            if (r_sqv >= sq_try) begin
                r_sqv  <= r_sqv - sq_try;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div_init) begin
            r_rem <= {2'b00, dabs};
            r_quo <= '0;
        end
        if (i_cmd.div_run) begin
            r_rem <= {div_diff[32:0], 1'b0};
            r_quo <= {r_quo[FRACTION_BITS-1:0], div_ge};
        end
        if (i_cmd.div_end) begin
            if (len == 32'd0) begin
                r_u[ax] <= '0;
            end else begin
                r_u[ax] <= r_d[ax][31] ? -quo_ext : quo_ext;
            end
        end
        if (i_cmd.out_load) begin
            r_out.leader_x     <= r_lp[0];
            r_out.leader_y     <= r_lp[1];
            r_out.follower_x   <= r_fp[0];
            r_out.follower_y   <= r_fp[1];
            r_out.link_force_x <= r_lf[0];
            r_out.link_force_y <= r_lf[1];
        end
    end

    // body state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_mass    <= ONE_RST;
            r_body_damp   <= ONE_RST;
            r_body_spring <= ONE_RST;
            r_link_spring <= SEVEN_RST;
            r_link_damp   <= ONE_RST;
            r_fol_gain    <= ONE_RST;
            r_rest_len    <= REST_RST;
            for (int i = 0; i < 2; i++) begin
                r_rv[i] <= '0;
                r_ra[i] <= '0;
                r_fv[i] <= '0;
                r_ef[i] <= '0;
                r_lf[i] <= '0;
            end
            r_rp[0] <= ONE;
            r_rp[1] <= '0;
            r_lp[0] <= ONE;
            r_lp[1] <= '0;
            r_lv[0] <= '0;
            r_lv[1] <= ONE;
            r_la[0] <= '0;
            r_la[1] <= ONE;
            r_fp[0] <= TWO;
            r_fp[1] <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_INVERSE_MASS:  r_inv_mass    <= i_cfg_data;
                    CFG_BODY_DAMPING:  r_body_damp   <= i_cfg_data;
                    CFG_BODY_SPRING:   r_body_spring <= i_cfg_data;
                    CFG_LINK_SPRING:   r_link_spring <= i_cfg_data;
                    CFG_LINK_DAMPING:  r_link_damp   <= i_cfg_data;
                    CFG_FOLLOWER_GAIN: r_fol_gain    <= i_cfg_data;
                    CFG_REST_LENGTH:   r_rest_len    <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                if (i_in_data.op == OP_PRESS) begin
                    r_ef[0] <= f_sub(i_in_data.pointer_x, r_lp[0]);
                    r_ef[1] <= f_sub(i_in_data.pointer_y, r_lp[1]);
                end else if (i_in_data.op == OP_RELEASE) begin
                    r_ef[0] <= '0;
                    r_ef[1] <= '0;
                end
            end
            if (i_cmd.wb) begin
                case (i_cmd.step)
                    STEP_RP:    r_rp[ax] <= f_add(r_rp[ax], q);
                    STEP_RV: begin
                        r_rv[ax] <= f_add(r_rv[ax], q);
                        r_ra[ax] <= r_acc[ax];
                    end
                    STEP_LP:    r_lp[ax] <= f_add(r_lp[ax], q);
                    STEP_LV:    r_lv[ax] <= f_add(r_lv[ax], q);
                    STEP_IMASS: r_la[ax] <= f_add(r_ra[ax], q);
                    STEP_FG: begin
                        r_lf[ax] <= r_t;
                        r_ef[ax] <= f_sub('0, r_t);
                    end
                    STEP_FV:    r_fv[ax] <= f_add(r_fv[ax], q);
                    STEP_FP:    r_fp[ax] <= f_add(r_fp[ax], q);
                    default: ;
                endcase
            end
        end
    end

    a_root_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_init |-> r_root[63:32] == 32'd0)
        else $error("link length wider than 32 bits");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_run && (len != 32'd0) |-> r_rem < {1'b0, len, 1'b0})
        else $error("divide remainder out of range");

endmodule

// File: rtl/coupled_spring_damper_step.sv
`timescale 1ns / 1ps
// Tick: the result is set by 28 multiplies on one shared multiplier, a square root and
// two divides; o_in_ready rises in the same cycle as o_out_valid.
// Press, release and unused op: no multiplies; the result goes valid once the output
// register is free.
// Synchronous active-low reset restores the initial bodies and register defaults.
module coupled_spring_damper_step #(
    parameter int FRACTION_BITS = csds_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  csds_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output csds_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [csds_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [csds_pkg::CFG_W-1:0]      i_cfg_data
);
    import csds_pkg::*;

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    csds_ctrl #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_in_data.op),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    csds_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_out_data)
    );

endmodule
